/* sv/gctp_pkg.sv */
// ----------------------------------------------------------------------------
// gctp_pkg - shared definitions for the coordinate text parser
// Fixed-point format, status codes, parse phases and decimal weights.
// ----------------------------------------------------------------------------
`default_nettype none

package gctp_pkg;

    // Fixed-point format of the result: degrees times 2^FRAC_BITS
    localparam int FRAC_BITS    = 24;
    localparam int MAX_DECIMALS = 8;
    // Fraction accumulator: minutes can reach 1.65 degrees
    localparam int FRAC_W       = FRAC_BITS + 2;
    localparam int DEG_W        = 8;
    localparam int COORD_W      = 33;
    localparam int POS_W        = 4;

    typedef logic [1:0]         status_t;
    typedef logic [1:0]         phase_t;
    typedef logic [FRAC_W-1:0]  frac_t;

    // Status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FORMAT  = 2'd1;
    localparam status_t ST_MINUTES = 2'd2;
    localparam status_t ST_RANGE   = 2'd3;

    // Parse phases
    localparam phase_t PH_INT = 2'd0;
    localparam phase_t PH_MIN = 2'd1;
    localparam phase_t PH_DEC = 2'd2;

    // Bit positions in the seen-flags vector
    localparam int SEEN_SIGN   = 0;
    localparam int SEEN_DIGIT  = 1;
    localparam int SEEN_LETTER = 2;
    localparam int SEEN_POINT  = 3;

    // Integer degree limits
    localparam logic [DEG_W-1:0] LAT_LIMIT = 8'd90;
    localparam logic [DEG_W-1:0] LON_LIMIT = 8'd180;

    // Characters
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [63:0] POW10 [0:9] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
        64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000
    };

    localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;

endpackage

`default_nettype wire

/* sv/geo_coordinate_text_parser.sv */
// ----------------------------------------------------------------------------
// geo_coordinate_text_parser - latitude / longitude text to fixed point
// Parses one character per item; the NUL terminator releases a status and
// a signed degree value with FRAC_BITS fraction bits, then clears the parse.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  --------  ----------------------  -------------------------------
//  input     in_valid / in_stall     ch (8 bits)
//  result    out_valid / out_stall   status (2), coordinate (33, signed)
//  config    cfg_valid / cfg_ready   cfg_data (axis_mode, 1 bit)
//
//  One character is taken every cycle while in_stall is low; its effect
//  on the parse state is settled in the same cycle, and a terminator
//  loads the result register; the result shows in the cycle after the NUL.
//  Only a NUL can be held off: in_stall rises while a result still waits
//  in the output register and the sink stalls. Other characters flow on.
//  Reset (rst_n, asynchronous) clears the parse state, the output valid
//  and axis_mode (latitude).
// ----------------------------------------------------------------------------
`default_nettype none

module geo_coordinate_text_parser
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_data,
    // character input
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        ch,
    // result output
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output gctp_pkg::status_t                      status,
    output logic signed [gctp_pkg::COORD_W-1:0]    coordinate
);

    import gctp_pkg::*;

    // ------------------------------------------------------------------
    // Constant weight tables, worked out at elaboration.
    // Decimal table rows outside 1..MAX_DECIMALS hold zero, so the
    // saturated position counter can index it directly.
    // ------------------------------------------------------------------
    frac_t min1_tab [0:9];
    frac_t min2_tab [0:9];
    frac_t dec_tab  [0:(1 << POS_W) - 1][0:9];

    for (genvar d = 0; d < 10; d++) begin : g_min
        localparam logic [63:0] M1 = (64'(d) * UNIT) / 64'd6;
        localparam logic [63:0] M2 = (64'(d) * UNIT) / 64'd60;
        assign min1_tab[d] = M1[FRAC_W-1:0];
        assign min2_tab[d] = M2[FRAC_W-1:0];
    end

    for (genvar p = 0; p < (1 << POS_W); p++) begin : g_dec_pos
        for (genvar d = 0; d < 10; d++) begin : g_dec_dig
            if (p >= 1 && p <= MAX_DECIMALS && p <= 9) begin : g_used
                localparam logic [63:0] W = (64'(d) * UNIT) / POW10[p];
                assign dec_tab[p][d] = W[FRAC_W-1:0];
            end
            else begin : g_zero
                assign dec_tab[p][d] = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                    axis_mode_reg;
    logic [DEG_W-1:0]        whole_reg,    whole_next;
    frac_t                   frac_reg,     frac_next;
    logic                    negative_reg, negative_next;
    logic [3:0]              seen_reg,     seen_next;
    phase_t                  phase_reg,    phase_next;
    logic [POS_W-1:0]        pos_reg,      pos_next;
    status_t                 error_reg,    error_next;

    logic                    out_valid_reg;
    status_t                 status_reg;
    logic [COORD_W-1:0]      coord_reg;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic is_nul;
    logic in_accept;
    logic term_accept;

    assign cfg_ready   = 1'b1;
    assign is_nul      = (ch == CH_NUL);
    // Hold a terminator only while the output register is occupied and stalled
    assign in_stall    = is_nul && out_valid_reg && out_stall;
    assign in_accept   = in_valid && !in_stall;
    assign term_accept = in_accept && is_nul;

    // ------------------------------------------------------------------
    // Character step
    // ------------------------------------------------------------------
    logic [3:0]         digit;
    logic [DEG_W-1:0]   limit;
    logic [10:0]        int_value;
    logic [POS_W-1:0]   pos_inc;

    assign digit     = ch[3:0];
    assign limit     = axis_mode_reg ? LON_LIMIT : LAT_LIMIT;
    assign int_value = 11'(whole_reg) * 11'd10 + 11'(digit);
    assign pos_inc   = pos_reg + POS_W'(1);

    always_comb
    begin
        whole_next    = whole_reg;
        frac_next     = frac_reg;
        negative_next = negative_reg;
        seen_next     = seen_reg;
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        error_next    = error_reg;

        if (in_accept)
        begin
            if (is_nul)
            begin
                // Terminator: drop the parse back to its reset state
                whole_next    = '0;
                frac_next     = '0;
                negative_next = 1'b0;
                seen_next     = '0;
                phase_next    = PH_INT;
                pos_next      = '0;
                error_next    = ST_OK;
            end
            else if (error_reg == ST_OK)
            begin
                unique case (ch) inside
                    ["0":"9"]:
                    begin
                        seen_next[SEEN_DIGIT] = 1'b1;
                        if (phase_reg == PH_INT)
                        begin
                            if (int_value > 11'(limit))
                                error_next = ST_RANGE;
                            else
                                whole_next = int_value[DEG_W-1:0];
                        end
                        else if (phase_reg == PH_MIN)
                        begin
                            pos_next = pos_inc;
                            if (pos_inc > POS_W'(2))
                                error_next = ST_MINUTES;
                            else if (pos_inc == POS_W'(1))
                                frac_next = frac_reg + min1_tab[digit];
                            else
                                frac_next = frac_reg + min2_tab[digit];
                        end
                        else
                        begin
                            // Saturate the decimal position; deep digits add zero
                            if (pos_reg != '1)
                                pos_next = pos_inc;
                            frac_next = frac_reg + dec_tab[pos_next][digit];
                        end
                    end
                    "N", "n", "S", "s", "E", "e", "W", "w":
                    begin
                        if (seen_reg[SEEN_LETTER] || seen_reg[SEEN_SIGN]
                            || seen_reg[SEEN_POINT])
                        begin
                            error_next = ST_FORMAT;
                        end
                        else
                        begin
                            seen_next[SEEN_LETTER] = 1'b1;
                            // E/W belong to longitude, N/S to latitude
                            if (axis_mode_reg != (ch == "E" || ch == "e"
                                                  || ch == "W" || ch == "w"))
                            begin
                                error_next = ST_FORMAT;
                            end
                            else
                            begin
                                phase_next    = PH_MIN;
                                negative_next = (ch == "S" || ch == "s"
                                                 || ch == "W" || ch == "w");
                            end
                        end
                    end
                    "+", "-":
                    begin
                        if (seen_reg[SEEN_LETTER] || seen_reg[SEEN_DIGIT]
                            || seen_reg[SEEN_POINT])
                        begin
                            error_next = ST_FORMAT;
                        end
                        else
                        begin
                            seen_next[SEEN_SIGN] = 1'b1;
                            negative_next        = (ch == "-");
                        end
                    end
                    ".", ",":
                    begin
                        if (seen_reg[SEEN_LETTER] || seen_reg[SEEN_POINT])
                        begin
                            error_next = ST_FORMAT;
                        end
                        else
                        begin
                            seen_next[SEEN_POINT] = 1'b1;
                            phase_next            = PH_DEC;
                        end
                    end
                    default:
                    begin
                        error_next = ST_FORMAT;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result value: magnitude, then two's complement when negative.
    // Negative zero comes out as zero on its own.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] magnitude;
    logic [COORD_W-1:0] signed_value;

    assign magnitude    = (COORD_W'(whole_reg) << FRAC_BITS) + COORD_W'(frac_reg);
    assign signed_value = negative_reg ? (COORD_W'(0) - magnitude) : magnitude;

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_mode_reg <= 1'b0;
            whole_reg     <= '0;
            frac_reg      <= '0;
            negative_reg  <= 1'b0;
            seen_reg      <= '0;
            phase_reg     <= PH_INT;
            pos_reg       <= '0;
            error_reg     <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                axis_mode_reg <= cfg_data;

            whole_reg    <= whole_next;
            frac_reg     <= frac_next;
            negative_reg <= negative_next;
            seen_reg     <= seen_next;
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            error_reg    <= error_next;

            // Advance the output register: load on a terminator, drop when taken
            if (term_accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded only with a terminator
    always_ff @(posedge clk)
    begin
        if (term_accept)
        begin
            status_reg <= error_reg;
            coord_reg  <= (error_reg == ST_OK) ? signed_value : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign coordinate = coord_reg;

endmodule

`default_nettype wire
